### sv/tvf_pkg.sv
// shared constants, types and codes for the text view filter
`timescale 1ns / 1ps
`default_nettype none
package tvf_pkg;

	localparam int NUMBER_DIGITS = 6;
	localparam int DIGITS_W      = 4 * NUMBER_DIGITS;
	localparam int NUM_LEN       = NUMBER_DIGITS + 1;
	localparam int BODY_LEN      = 4;
	localparam int BLEN_W        = $clog2(BODY_LEN + 1);
	localparam int MAX_OUT       = NUM_LEN + BODY_LEN;
	localparam int CNT_W         = $clog2(MAX_OUT + 1);
	localparam int PTR_W         = $clog2(MAX_OUT);
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_DATA_W    = 8;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_NUMBER_MODE = 3'd0,
		REG_SHOW_ENDS   = 3'd1,
		REG_SQUEEZE     = 3'd2,
		REG_SHOW_TABS   = 3'd3,
		REG_SHOW_NP     = 3'd4
	} cfg_reg_t;

	localparam logic [1:0] NUM_ALL      = 2'd1;
	localparam logic [1:0] NUM_NONBLANK = 2'd2;

	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_NL      = 8'h0A;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_DOLLAR  = 8'h24;
	localparam logic [7:0] CH_DASH    = 8'h2D;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_QMARK   = 8'h3F;
	localparam logic [7:0] CH_I       = 8'h49;
	localparam logic [7:0] CH_M       = 8'h4D;
	localparam logic [7:0] CH_CARET   = 8'h5E;
	localparam logic [7:0] CH_DEL     = 8'd127;
	localparam logic [7:0] CH_CTRL_HI = 8'd32;
	localparam logic [7:0] CTRL_SHIFT = 8'd64;

	typedef struct packed {
		logic [1:0] number_mode;
		logic       show_ends;
		logic       squeeze_blank;
		logic       show_tabs;
		logic       show_nonprinting;
	} cfg_t;

	typedef struct packed {
		logic [BODY_LEN-1:0][7:0] bytes;
		logic [BLEN_W-1:0]        len;
	} body_t;

endpackage
`default_nettype wire

### sv/tvf_if.sv
// valid/ready channel interfaces for bytes in, text out and register writes
`timescale 1ns / 1ps
`default_nettype none
interface tvf_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       file_start;
	modport source (output valid, output data_byte, output file_start, input ready);
	modport sink   (input valid, input data_byte, input file_start, output ready);
	modport mon    (input valid, input data_byte, input file_start, input ready);
endinterface

interface tvf_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       run_last;
	modport source (output valid, output out_byte, output run_last, input ready);
	modport sink   (input valid, input out_byte, input run_last, output ready);
	modport mon    (input valid, input out_byte, input run_last, input ready);
endinterface

interface tvf_cfg_if
	import tvf_pkg::*;
();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
	modport mon    (input valid, input index, input data, input ready);
endinterface
`default_nettype wire

### sv/tvf_render.sv
// rendering of one file byte into its visible form, up to four bytes
`timescale 1ns / 1ps
`default_nettype none
module tvf_render
	import tvf_pkg::*;
(
	input  wire logic [7:0] data_byte,
	input  wire cfg_t       cfg,
	output body_t           body
);

	logic [7:0]      low;
	logic [1:0][7:0] tail;
	logic [1:0]      tail_len;

	always_comb begin
		body     = '0;
		low      = {1'b0, data_byte[6:0]};
		tail     = '0;
		tail_len = 2'd1;
		if (data_byte == CH_NL) begin
			if (cfg.show_ends) begin
				body.bytes[0] = CH_DOLLAR;
				body.bytes[1] = CH_NL;
				body.len      = BLEN_W'(2);
			end else begin
				body.bytes[0] = CH_NL;
				body.len      = BLEN_W'(1);
			end
		end else if (data_byte == CH_TAB && cfg.show_tabs) begin
			body.bytes[0] = CH_CARET;
			body.bytes[1] = CH_I;
			body.len      = BLEN_W'(2);
		end else if (cfg.show_nonprinting) begin
			if (low == CH_DEL) begin
				tail[0]  = CH_CARET;
				tail[1]  = CH_QMARK;
				tail_len = 2'd2;
			end else if (low < CH_CTRL_HI
					&& !(!data_byte[7] && (low == CH_TAB || low == CH_NL))) begin
				tail[0]  = CH_CARET;
				tail[1]  = low + CTRL_SHIFT;
				tail_len = 2'd2;
			end else begin
				tail[0] = low;
			end
			// high bytes get the meta prefix ahead of the low-7-bit form
			if (data_byte[7]) begin
				body.bytes[0] = CH_M;
				body.bytes[1] = CH_DASH;
				body.bytes[2] = tail[0];
				body.bytes[3] = tail[1];
				body.len      = BLEN_W'(2) + BLEN_W'(tail_len);
			end else begin
				body.bytes[0] = tail[0];
				body.bytes[1] = tail[1];
				body.len      = BLEN_W'(tail_len);
			end
		end else begin
			body.bytes[0] = data_byte;
			body.len      = BLEN_W'(1);
		end
	end

endmodule
`default_nettype wire

### sv/text_view_filter_top.sv
// top level of the text view filter: line state, item register and text output
//
// Takes one file byte per request and emits its cat-style rendering, one text byte
// per cycle from a registered output while the receiver is ready. A byte's rendering
// is k text bytes long (k is 1 to NUMBER_DIGITS + 5, 0 for a squeezed blank line);
// the next byte is taken in the cycle the last text byte of the current one is loaded
// into the output register, so plain text streams at one byte per cycle. Line state
// and the BCD line counter update when a byte is taken; the counter stops at all nines.
// Register writes are taken in any cycle and must only be made while the block is idle.
`timescale 1ns / 1ps
`default_nettype none
module text_view_filter_top
	import tvf_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	tvf_in_if.sink     byte_ch,
	tvf_out_if.source  text_ch,
	tvf_cfg_if.sink    cfg_ch
);

	function automatic logic [DIGITS_W-1:0] bcd_inc_sat(input logic [DIGITS_W-1:0] d);
		logic [DIGITS_W-1:0] r;
		logic                all_nine;
		logic                carry;
		logic [3:0]          nib;
		r        = d;
		all_nine = 1'b1;
		carry    = 1'b1;
		for (int i = 0; i < NUMBER_DIGITS; i++) begin
			if (d[4*i +: 4] != 4'd9) all_nine = 1'b0;
		end
		for (int i = 0; i < NUMBER_DIGITS; i++) begin
			nib = d[4*i +: 4];
			if (carry) begin
				if (nib == 4'd9) begin
					r[4*i +: 4] = 4'd0;
				end else begin
					r[4*i +: 4] = nib + 4'd1;
					carry       = 1'b0;
				end
			end
		end
		return all_nine ? d : r;
	endfunction

	function automatic logic [NUM_LEN-1:0][7:0] number_text(input logic [DIGITS_W-1:0] d);
		logic [NUM_LEN-1:0][7:0] t;
		logic                    lead;
		logic [3:0]              nib;
		lead = 1'b1;
		for (int i = NUMBER_DIGITS - 1; i >= 0; i--) begin
			nib = d[4*i +: 4];
			if (lead && nib == 4'd0 && i > 0) begin
				t[NUMBER_DIGITS-1-i] = CH_SPACE;
			end else begin
				lead                 = 1'b0;
				t[NUMBER_DIGITS-1-i] = CH_ZERO + {4'd0, nib};
			end
		end
		t[NUMBER_DIGITS] = CH_TAB;
		return t;
	endfunction

	cfg_t                         cfg_q;
	logic                         at_start_q;
	logic                         prev_blank_q;
	logic [DIGITS_W-1:0]          digits_q;

	logic                         item_valid_s1;
	logic [MAX_OUT-1:0][7:0]      item_bytes_s1;
	logic [CNT_W-1:0]             item_cnt_s1;
	logic [PTR_W-1:0]             ptr_q;

	logic                         out_valid_q;
	logic [7:0]                   out_byte_q;
	logic                         out_last_q;

	body_t                        body;
	logic                         is_nl;
	logic                         eff_start;
	logic                         eff_prev;
	logic [DIGITS_W-1:0]          eff_digits;
	logic                         drop;
	logic                         num_en;
	logic                         next_prev;
	logic [NUM_LEN-1:0][7:0]      num_txt;
	logic [MAX_OUT-1:0][7:0]      line_bytes;
	logic [CNT_W-1:0]             line_cnt;
	logic                         out_free;
	logic                         emit;
	logic                         at_last;
	logic                         accept;

	tvf_render u_render (
		.data_byte (byte_ch.data_byte),
		.cfg       (cfg_q),
		.body      (body)
	);

	// register writes
	assign cfg_ch.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_ch.valid) begin
			unique case (cfg_reg_t'(cfg_ch.index))
				REG_NUMBER_MODE: cfg_q.number_mode      <= cfg_ch.data[1:0];
				REG_SHOW_ENDS:   cfg_q.show_ends        <= cfg_ch.data[0];
				REG_SQUEEZE:     cfg_q.squeeze_blank    <= cfg_ch.data[0];
				REG_SHOW_TABS:   cfg_q.show_tabs        <= cfg_ch.data[0];
				REG_SHOW_NP:     cfg_q.show_nonprinting <= cfg_ch.data[0];
				default: ;
			endcase
		end
	end

	// line state seen by the incoming byte
	always_comb begin
		is_nl      = (byte_ch.data_byte == CH_NL);
		eff_start  = byte_ch.file_start | at_start_q;
		eff_prev   = !byte_ch.file_start & prev_blank_q;
		eff_digits = byte_ch.file_start ? DIGITS_W'(1) : digits_q;
		drop       = eff_start && cfg_q.squeeze_blank && is_nl && eff_prev;
		next_prev  = (eff_start && cfg_q.squeeze_blank) ? is_nl : eff_prev;
		num_en     = eff_start && !drop
			&& (cfg_q.number_mode == NUM_ALL
				|| (cfg_q.number_mode == NUM_NONBLANK && !is_nl));
		num_txt    = number_text(eff_digits);
		line_bytes = num_en ? {body.bytes, num_txt} : {{NUM_LEN{8'h00}}, body.bytes};
		line_cnt   = num_en ? CNT_W'(NUM_LEN) + CNT_W'(body.len) : CNT_W'(body.len);
	end

	// text emission
	assign out_free = !out_valid_q || text_ch.ready;
	assign emit     = item_valid_s1 && out_free;
	assign at_last  = (CNT_W'(ptr_q) + CNT_W'(1)) == item_cnt_s1;
	assign byte_ch.ready = !item_valid_s1 || (emit && at_last);
	assign accept   = byte_ch.valid && byte_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			at_start_q   <= 1'b1;
			prev_blank_q <= 1'b0;
			digits_q     <= DIGITS_W'(1);
		end else if (accept) begin
			at_start_q   <= is_nl;
			prev_blank_q <= next_prev;
			digits_q     <= num_en ? bcd_inc_sat(eff_digits) : eff_digits;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
			ptr_q         <= '0;
		end else if (accept && !drop) begin
			item_valid_s1 <= 1'b1;
			ptr_q         <= '0;
		end else if (emit && at_last) begin
			item_valid_s1 <= 1'b0;
		end else if (emit) begin
			ptr_q <= ptr_q + PTR_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !drop) begin
			item_bytes_s1 <= line_bytes;
			item_cnt_s1   <= line_cnt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (text_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q <= item_bytes_s1[ptr_q];
			out_last_q <= at_last;
		end
	end

	assign text_ch.valid    = out_valid_q;
	assign text_ch.out_byte = out_byte_q;
	assign text_ch.run_last = out_last_q;

endmodule
`default_nettype wire

### sv/tvf_checker.sv
// port-level assertions for the text view filter and their bind
`timescale 1ns / 1ps
`default_nettype none
module tvf_checker
	import tvf_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_ready,
	input  wire logic       out_valid,
	input  wire logic       out_ready,
	input  wire logic [7:0] out_byte,
	input  wire logic       out_last
);

	// a stalled text byte holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=>
			out_valid && $stable(out_byte) && $stable(out_last))
		else $error("text byte changed while stalled");

	// the rest of a rendering follows without a gap
	a_run_gapless: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_last |=> out_valid)
		else $error("gap inside a rendering");

	// a newline always closes the rendering of its byte
	a_nl_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_byte == CH_NL |-> out_last)
		else $error("newline not last in its rendering");

	// request ready is always a known level
	a_in_ready_known: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown(in_ready))
		else $error("request ready unknown");

endmodule

bind text_view_filter_top tvf_checker u_tvf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (byte_ch.ready),
	.out_valid (text_ch.valid),
	.out_ready (text_ch.ready),
	.out_byte  (text_ch.out_byte),
	.out_last  (text_ch.run_last)
);
`default_nettype wire

### tb/sv/text_view_filter_top_tb.sv
// self-checking testbench for text_view_filter_top: predicts the rendered text of each byte
`timescale 1ns / 1ps
module text_view_filter_top_tb;
	import tvf_pkg::*;

	localparam logic [1:0] NUM_OFF    = 2'd0;
	localparam logic [1:0] NUM_UNUSED = 2'd3;
	localparam int IDLE_PCT    = 37;
	localparam int QUIET       = 2 * MAX_OUT + 8;
	localparam int CYCLE_LIMIT = 300000;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
	} text_beat_t;

	logic clk;
	logic arst_n;

	tvf_in_if  byte_ch ();
	tvf_out_if text_ch ();
	tvf_cfg_if cfg_ch ();

	text_view_filter_top u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.byte_ch(byte_ch),
		.text_ch(text_ch),
		.cfg_ch (cfg_ch)
	);

	// line state and settings of the predictor
	cfg_t                           view_cfg;
	logic                           line_open;
	logic                           last_blank;
	logic [NUMBER_DIGITS-1:0][3:0]  line_bcd;

	logic [7:0] rendered[$];
	text_beat_t text_expected[$];
	text_beat_t want;

	int  mismatches;
	int  cycle_count;
	int  hold_cycles;
	bit  steady;

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t timeout, %0d text bytes still expected", $time, text_expected.size());
			$display("** text_view_filter_top: FAILED **");
			$finish;
		end
	end

	// text receiver
	initial begin
		text_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				text_ch.ready <= 1'b0;
				hold_cycles = hold_cycles - 1;
			end else if (steady) begin
				text_ch.ready <= 1'b1;
			end else begin
				text_ch.ready <= ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	// text checker
	always @(posedge clk) begin
		if (arst_n && text_ch.valid && text_ch.ready) begin
			if (text_expected.size() == 0) begin
				$display("%0t unexpected text byte: expected none, actual %h run_last %b",
					$time, text_ch.out_byte, text_ch.run_last);
				mismatches++;
			end else begin
				want = text_expected.pop_front();
				if (text_ch.out_byte !== want.out_byte) begin
					$display("%0t out_byte: expected %h, actual %h",
						$time, want.out_byte, text_ch.out_byte);
					mismatches++;
				end
				if (text_ch.run_last !== want.run_last) begin
					$display("%0t run_last: expected %b, actual %b",
						$time, want.run_last, text_ch.run_last);
					mismatches++;
				end
			end
		end
	end

	function automatic void reset_view();
		view_cfg   = '0;
		line_open  = 1'b1;
		last_blank = 1'b0;
		line_bcd   = '0;
		line_bcd[0] = 4'd1;
	endfunction

	function automatic void put_line_number();
		logic lead;
		logic all_nine;
		logic carry;
		lead = 1'b1;
		all_nine = 1'b1;
		carry = 1'b1;
		for (int i = NUMBER_DIGITS - 1; i >= 0; i--) begin
			if (lead && line_bcd[i] == 4'd0 && i > 0) begin
				rendered.push_back(CH_SPACE);
			end else begin
				lead = 1'b0;
				rendered.push_back(CH_ZERO + {4'd0, line_bcd[i]});
			end
			if (line_bcd[i] != 4'd9)
				all_nine = 1'b0;
		end
		rendered.push_back(CH_TAB);
		// counter stops at all nines
		if (!all_nine) begin
			for (int i = 0; i < NUMBER_DIGITS; i++) begin
				if (carry) begin
					if (line_bcd[i] == 4'd9) begin
						line_bcd[i] = 4'd0;
					end else begin
						line_bcd[i] = line_bcd[i] + 4'd1;
						carry = 1'b0;
					end
				end
			end
		end
	endfunction

	function automatic void render_byte(input logic [7:0] c, input logic fs);
		logic [7:0] low;
		rendered.delete();
		if (fs) begin
			line_open  = 1'b1;
			last_blank = 1'b0;
			line_bcd   = '0;
			line_bcd[0] = 4'd1;
		end
		if (line_open) begin
			if (view_cfg.squeeze_blank) begin
				if (c == CH_NL) begin
					// squeezed blank line: nothing comes out
					if (last_blank)
						return;
					last_blank = 1'b1;
				end else begin
					last_blank = 1'b0;
				end
			end
			if (view_cfg.number_mode == NUM_ALL ||
					(view_cfg.number_mode == NUM_NONBLANK && c != CH_NL))
				put_line_number();
		end
		line_open = (c == CH_NL);
		if (c == CH_NL) begin
			if (view_cfg.show_ends)
				rendered.push_back(CH_DOLLAR);
			rendered.push_back(CH_NL);
		end else if (c == CH_TAB && view_cfg.show_tabs) begin
			rendered.push_back(CH_CARET);
			rendered.push_back(CH_I);
		end else if (view_cfg.show_nonprinting) begin
			low = c;
			if (c[7]) begin
				rendered.push_back(CH_M);
				rendered.push_back(CH_DASH);
				low = {1'b0, c[6:0]};
			end
			if (low == CH_DEL) begin
				rendered.push_back(CH_CARET);
				rendered.push_back(CH_QMARK);
			end else if (low < CH_CTRL_HI && !(!c[7] && (low == CH_TAB || low == CH_NL))) begin
				rendered.push_back(CH_CARET);
				rendered.push_back(low + CTRL_SHIFT);
			end else begin
				rendered.push_back(low);
			end
		end else begin
			rendered.push_back(c);
		end
		foreach (rendered[i])
			text_expected.push_back('{out_byte: rendered[i], run_last: (i == rendered.size() - 1)});
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic fs);
		render_byte(b, fs);
		@(negedge clk);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			byte_ch.valid <= 1'b0;
			@(negedge clk);
		end
		byte_ch.valid      <= 1'b1;
		byte_ch.data_byte  <= b;
		byte_ch.file_start <= fs;
		do
			@(posedge clk);
		while (!byte_ch.ready);
	endtask

	// sender stops until all text is out, then lets the block settle
	task automatic wait_idle();
		@(negedge clk);
		byte_ch.valid <= 1'b0;
		while (text_expected.size() != 0)
			@(posedge clk);
		repeat (QUIET) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [7:0] value);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= value;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		case (idx)
			REG_NUMBER_MODE: view_cfg.number_mode      = value[1:0];
			REG_SHOW_ENDS:   view_cfg.show_ends        = value[0];
			REG_SQUEEZE:     view_cfg.squeeze_blank    = value[0];
			REG_SHOW_TABS:   view_cfg.show_tabs        = value[0];
			REG_SHOW_NP:     view_cfg.show_nonprinting = value[0];
			default: ;
		endcase
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic set_view(input logic [1:0] nm, input logic ends, input logic sq,
			input logic tabs, input logic np);
		wait_idle();
		write_reg(REG_NUMBER_MODE, {6'd0, nm});
		write_reg(REG_SHOW_ENDS, {7'd0, ends});
		write_reg(REG_SQUEEZE, {7'd0, sq});
		write_reg(REG_SHOW_TABS, {7'd0, tabs});
		write_reg(REG_SHOW_NP, {7'd0, np});
	endtask

	function automatic logic [7:0] pick_text_char();
		int roll;
		roll = $urandom_range(99);
		if (roll < 10)
			return CH_TAB;
		else if (roll < 18)
			return 8'($urandom_range(31));
		else if (roll < 25)
			return 8'($urandom_range(255, 128));
		else if (roll < 27)
			return CH_DEL;
		else
			return 8'($urandom_range(126, 32));
	endfunction

	// mostly lines with blank runs between them, some raw noise bytes
	task automatic send_random_text(input int count);
		int sent;
		int blanks;
		int len;
		logic fs;
		sent = 0;
		while (sent < count) begin
			if ($urandom_range(99) < 15) begin
				send_byte(8'($urandom_range(255)), ($urandom_range(19) == 0));
				sent++;
			end else begin
				blanks = ($urandom_range(2) == 0) ? $urandom_range(3, 1) : 0;
				len = $urandom_range(8);
				fs = ($urandom_range(24) == 0);
				for (int i = 0; i < blanks; i++) begin
					send_byte(CH_NL, fs);
					fs = 1'b0;
				end
				for (int i = 0; i < len; i++) begin
					send_byte(pick_text_char(), fs);
					fs = 1'b0;
				end
				send_byte(CH_NL, fs);
				sent += blanks + len + 1;
			end
		end
	endtask

	task automatic test_plain_bytes();
		set_view(NUM_OFF, 1'b0, 1'b0, 1'b0, 1'b0);
		send_byte(8'h00, 1'b1);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h41, 1'b0);
		send_byte(CH_TAB, 1'b0);
		send_byte(CH_DEL, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(CH_NL, 1'b0);
	endtask

	task automatic test_notation();
		set_view(NUM_OFF, 1'b1, 1'b0, 1'b1, 1'b1);
		send_byte(CH_TAB, 1'b0);
		send_byte(CH_NL, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h1F, 1'b0);
		send_byte(CH_DEL, 1'b0);
		send_byte(8'h89, 1'b0);
		send_byte(8'h8A, 1'b0);
		send_byte(8'h9F, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h7E, 1'b0);
		set_view(NUM_OFF, 1'b0, 1'b0, 1'b0, 1'b1);
		send_byte(CH_TAB, 1'b0);
		send_byte(8'h89, 1'b0);
	endtask

	task automatic test_blank_lines();
		set_view(NUM_ALL, 1'b0, 1'b1, 1'b0, 1'b0);
		send_byte(8'h61, 1'b1);
		send_byte(CH_NL, 1'b0);
		send_byte(CH_NL, 1'b0);
		send_byte(CH_NL, 1'b0);
		send_byte(CH_NL, 1'b0);
		send_byte(8'h62, 1'b1);
		set_view(NUM_NONBLANK, 1'b1, 1'b1, 1'b0, 1'b0);
		send_byte(CH_NL, 1'b0);
		send_byte(CH_NL, 1'b0);
		send_byte(8'h63, 1'b0);
		set_view(NUM_UNUSED, 1'b0, 1'b1, 1'b0, 1'b0);
		send_byte(8'h64, 1'b0);
		send_byte(CH_NL, 1'b0);
		// blank tracking holds while squeezing is off
		set_view(NUM_OFF, 1'b0, 1'b0, 1'b0, 1'b0);
		send_byte(CH_NL, 1'b0);
		send_byte(CH_NL, 1'b0);
		set_view(NUM_OFF, 1'b0, 1'b1, 1'b0, 1'b0);
		send_byte(CH_NL, 1'b0);
		send_byte(CH_NL, 1'b0);
	endtask

	// numbers roll into two and three digits, no idling on either side
	task automatic test_line_count();
		set_view(NUM_ALL, 1'b0, 1'b0, 1'b0, 1'b0);
		steady = 1'b1;
		send_byte(CH_NL, 1'b1);
		repeat (100) send_byte(CH_NL, 1'b0);
		wait_idle();
		steady = 1'b0;
	endtask

	task automatic test_backpressure();
		set_view(NUM_NONBLANK, 1'b1, 1'b0, 1'b1, 1'b1);
		@(negedge clk);
		hold_cycles = 200;
		send_random_text(30);
		wait_idle();
	endtask

	task automatic test_random_views();
		set_view(NUM_OFF, 1'b0, 1'b0, 1'b0, 1'b0);
		send_random_text(20);
		set_view(NUM_NONBLANK, 1'b1, 1'b1, 1'b1, 1'b1);
		send_random_text(20);
		for (int p = 0; p < 4; p++) begin
			set_view(2'($urandom_range(3)), 1'($urandom_range(1)), 1'($urandom_range(1)),
				1'($urandom_range(1)), 1'($urandom_range(1)));
			send_random_text(10);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		byte_ch.valid = 1'b0;
		byte_ch.data_byte = '0;
		byte_ch.file_start = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_NUMBER_MODE;
		cfg_ch.data = '0;
		mismatches = 0;
		cycle_count = 0;
		hold_cycles = 0;
		steady = 1'b0;
		reset_view();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_plain_bytes();
		test_notation();
		test_blank_lines();
		test_line_count();
		test_backpressure();
		test_random_views();

		wait_idle();
		if (mismatches == 0) begin
			$display("** text_view_filter_top: PASSED **");
		end else begin
			$display("** text_view_filter_top: FAILED **");
		end
		$finish;
	end

endmodule
